// ===== sv/mrip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrip_pkg
// Shared types and constants for the ramped incremental PID speed controller.
// ----------------------------------------------------------------------------
package mrip_pkg;

  localparam int CH_W       = 2;
  localparam int SPEED_W    = 16;
  localparam int GAIN_W     = 12;
  localparam int DRIVE_W    = 14;
  localparam int ERR_W      = 18;
  localparam int MAG_W      = 16;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  localparam int DEF_CHANNELS       = 4;
  localparam int DEF_GAIN_FRAC_BITS = 8;
  localparam int QUEUE_DEPTH        = 4;

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_TARGET  = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_GAIN_P      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DEAD_ZONE   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SPEED_CEIL  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RAMP_STEP   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_MIN_DRIVE   = 3'd7;

  localparam logic [GAIN_W-1:0]  RST_GAIN_P      = 12'd512;
  localparam logic [GAIN_W-1:0]  RST_GAIN_I      = 12'd38;
  localparam logic [GAIN_W-1:0]  RST_GAIN_D      = 12'd20;
  localparam logic [DRIVE_W-1:0] RST_DRIVE_LIMIT = 14'd9500;
  localparam logic [DRIVE_W-1:0] RST_DEAD_ZONE   = 14'd50;
  localparam logic [DRIVE_W-1:0] RST_SPEED_CEIL  = 14'd9500;
  localparam logic [DRIVE_W-1:0] RST_RAMP_STEP   = 14'd1000;
  localparam logic [DRIVE_W-1:0] RST_MIN_DRIVE   = 14'd100;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [DRIVE_W-1:0] drive_limit;
    logic [DRIVE_W-1:0] error_dead_zone;
    logic [DRIVE_W-1:0] speed_ceiling;
    logic [DRIVE_W-1:0] ramp_step;
    logic [DRIVE_W-1:0] min_drive;
  } cfg_t;

  // ramped command waiting for the pid
  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic             fwd;
    logic [MAG_W-1:0] ramped_mag;
    logic [MAG_W-1:0] cur_mag;
  } cmd_t;

endpackage

// ===== sv/mrip_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrip_front
// Accepts transactions, stores measurements, clamps and ramps targets.
// ----------------------------------------------------------------------------
module mrip_front #(
  parameter int CHANNELS = mrip_pkg::DEF_CHANNELS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic [mrip_pkg::CH_W-1:0]   in_ch,
  input  logic [mrip_pkg::SPEED_W-1:0] in_speed,
  input  mrip_pkg::cfg_t              cfg,
  output logic                        push,
  output mrip_pkg::cmd_t              push_cmd,
  input  logic                        q_full
);
  import mrip_pkg::*;

  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic                      f1_valid;
  logic                      f1_op;
  logic [CH_W-1:0]           f1_ch;
  logic signed [SPEED_W-1:0] f1_sv;

  logic                      f2_valid;
  logic [CH_W-1:0]           f2_ch;
  logic signed [SPEED_W-1:0] f2_tgt;
  logic signed [SPEED_W-1:0] f2_cur;
  logic signed [SPEED_W:0]   f2_diff;

  logic signed [SPEED_W-1:0] measured [CHANNELS];

  logic                      ch_ok;
  logic                      f1_keep;
  logic                      f1_adv;
  logic                      f2_adv;
  logic [CH_IDX_W-1:0]       f1_idx;
  logic signed [SPEED_W:0]   sv_ext;
  logic signed [SPEED_W:0]   ceil_pos;
  logic signed [SPEED_W-1:0] tgt;
  logic signed [SPEED_W-1:0] cur;

  logic [SPEED_W:0]          adiff;
  logic [DRIVE_W-1:0]        step;
  logic signed [SPEED_W:0]   cur_ext;
  logic signed [SPEED_W:0]   ramped;
  logic [SPEED_W:0]          ramped_abs;
  logic [SPEED_W:0]          cur_abs;

  assign ch_ok   = int'(f1_ch) < CHANNELS;
  assign f1_keep = (f1_op == OP_TARGET) && ch_ok;
  assign f2_adv  = f2_valid && !q_full;
  assign f1_adv  = f1_valid && (!f1_keep || !f2_valid || f2_adv);
  assign in_ready = !f1_valid || f1_adv;
  assign f1_idx  = CH_IDX_W'(f1_ch);

  // target clamp
  always_comb begin
    sv_ext   = (SPEED_W+1)'(f1_sv);
    ceil_pos = $signed({3'b000, cfg.speed_ceiling});
    if (sv_ext > ceil_pos) begin
      tgt = SPEED_W'(ceil_pos);
    end else if (sv_ext < -ceil_pos) begin
      tgt = SPEED_W'(-ceil_pos);
    end else begin
      tgt = f1_sv;
    end
    cur = measured[f1_idx];
  end

  // ramp toward the target
  always_comb begin
    adiff   = f2_diff[SPEED_W] ? unsigned'(-f2_diff) : unsigned'(f2_diff);
    step    = (adiff < {2'b00, cfg.ramp_step, 1'b0}) ? (cfg.ramp_step >> 1) : cfg.ramp_step;
    cur_ext = (SPEED_W+1)'(f2_cur);
    if (adiff < {3'b000, step}) begin
      ramped = (SPEED_W+1)'(f2_tgt);
    end else if (f2_diff > 0) begin
      ramped = cur_ext + $signed({3'b000, step});
    end else begin
      ramped = cur_ext - $signed({3'b000, step});
    end
    ramped_abs = ramped[SPEED_W] ? unsigned'(-ramped) : unsigned'(ramped);
    cur_abs    = cur_ext[SPEED_W] ? unsigned'(-cur_ext) : unsigned'(cur_ext);
  end

  assign push                = f2_adv;
  assign push_cmd.ch         = f2_ch;
  assign push_cmd.fwd        = !ramped[SPEED_W];
  assign push_cmd.ramped_mag = ramped_abs[MAG_W-1:0];
  assign push_cmd.cur_mag    = cur_abs[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        measured[i] <= '0;
      end
    end else begin
      if (in_ready) begin
        f1_valid <= in_valid;
      end
      if (f1_adv && f1_keep) begin
        f2_valid <= 1'b1;
      end else if (f2_adv) begin
        f2_valid <= 1'b0;
      end
      if (f1_adv && (f1_op == OP_MEASURE) && ch_ok) begin
        measured[f1_idx] <= f1_sv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      f1_op <= in_op;
      f1_ch <= in_ch;
      f1_sv <= in_speed;
    end
    if (f1_adv && f1_keep) begin
      f2_ch   <= f1_ch;
      f2_tgt  <= tgt;
      f2_cur  <= cur;
      f2_diff <= (SPEED_W+1)'(tgt) - (SPEED_W+1)'(cur);
    end
  end

endmodule

// ===== sv/mrip_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrip_queue
// Small command queue between the ramp front end and the pid back end.
// ----------------------------------------------------------------------------
module mrip_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mrip_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output mrip_pkg::cmd_t head,
  output logic           empty
);
  import mrip_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ===== sv/mrip_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrip_back
// Incremental pid per channel: error, gain products, accumulate, clamp, pwm.
// ----------------------------------------------------------------------------
module mrip_back #(
  parameter int CHANNELS       = mrip_pkg::DEF_CHANNELS,
  parameter int GAIN_FRAC_BITS = mrip_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mrip_pkg::cfg_t               cfg,
  input  mrip_pkg::cmd_t               head,
  input  logic                         empty,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mrip_pkg::CH_W-1:0]    out_ch,
  output logic [mrip_pkg::DRIVE_W-1:0] out_pwm,
  output logic                         out_fwd
);
  import mrip_pkg::*;

  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DIFF_W   = ERR_W + 2;
  localparam int PROD_W   = GAIN_W + DIFF_W + 1;
  localparam int ACC_W    = DRIVE_W + GAIN_FRAC_BITS + 2;
  localparam int SUM_W    = ((ACC_W > PROD_W) ? ACC_W : PROD_W) + 3;

  logic signed [ERR_W-1:0]  last_err  [CHANNELS];
  logic signed [ERR_W-1:0]  prior_err [CHANNELS];
  logic signed [ACC_W-1:0]  accum     [CHANNELS];

  logic                     a_valid;
  logic [CH_W-1:0]          a_ch;
  logic                     a_fwd;
  logic                     a_dead;
  logic signed [PROD_W-1:0] a_prod_p;
  logic signed [PROD_W-1:0] a_prod_i;
  logic signed [PROD_W-1:0] a_prod_d;

  logic                     a_adv;
  logic [CH_IDX_W-1:0]      h_idx;
  logic [CH_IDX_W-1:0]      a_idx;
  logic signed [ERR_W-1:0]  err;
  logic [ERR_W-2:0]         err_abs;
  logic                     dead;
  logic signed [DIFF_W-1:0] err_ext;
  logic signed [DIFF_W-1:0] le_ext;
  logic signed [DIFF_W-1:0] pe_ext;
  logic signed [DIFF_W-1:0] d1;
  logic signed [DIFF_W-1:0] d2;

  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  lim;
  logic signed [ACC_W-1:0]  acc_next;
  logic [DRIVE_W-1:0]       int_part;
  logic [DRIVE_W-1:0]       pwm;

  assign a_adv = a_valid && (!out_valid || out_ready);
  assign pop   = !empty && (!a_valid || a_adv);
  assign h_idx = CH_IDX_W'(head.ch);
  assign a_idx = CH_IDX_W'(a_ch);

  // error and differences
  always_comb begin
    err     = $signed({2'b00, head.ramped_mag}) - $signed({2'b00, head.cur_mag});
    err_abs = err[ERR_W-1] ? (ERR_W-1)'(-err) : err[ERR_W-2:0];
    dead    = err_abs < (ERR_W-1)'(cfg.error_dead_zone);
    err_ext = DIFF_W'(err);
    le_ext  = DIFF_W'(last_err[h_idx]);
    pe_ext  = DIFF_W'(prior_err[h_idx]);
    d1      = err_ext - le_ext;
    d2      = err_ext - (le_ext <<< 1) + pe_ext;
  end

  // accumulate and clamp
  always_comb begin
    sum = SUM_W'(accum[a_idx]) + SUM_W'(a_prod_p) + SUM_W'(a_prod_i) + SUM_W'(a_prod_d);
    lim = $signed(SUM_W'({cfg.drive_limit, {GAIN_FRAC_BITS{1'b0}}}));
    if (sum > lim) begin
      acc_next = ACC_W'(lim);
    end else if (sum < -lim) begin
      acc_next = ACC_W'(-lim);
    end else begin
      acc_next = ACC_W'(sum);
    end
    int_part = acc_next[GAIN_FRAC_BITS +: DRIVE_W];
    if (a_dead || acc_next[ACC_W-1] || (int_part < cfg.min_drive)) begin
      pwm = '0;
    end else begin
      pwm = int_part;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        last_err[i]  <= '0;
        prior_err[i] <= '0;
        accum[i]     <= '0;
      end
    end else begin
      if (pop) begin
        a_valid <= 1'b1;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
      if (a_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop && !dead) begin
        prior_err[h_idx] <= last_err[h_idx];
        last_err[h_idx]  <= err;
      end
      if (a_adv && !a_dead) begin
        accum[a_idx] <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_ch     <= head.ch;
      a_fwd    <= head.fwd;
      a_dead   <= dead;
      a_prod_p <= PROD_W'($signed({1'b0, cfg.gain_p})) * PROD_W'(d1);
      a_prod_i <= PROD_W'($signed({1'b0, cfg.gain_i})) * PROD_W'(err_ext);
      a_prod_d <= PROD_W'($signed({1'b0, cfg.gain_d})) * PROD_W'(d2);
    end
    if (a_adv) begin
      out_ch  <= a_ch;
      out_pwm <= pwm;
      out_fwd <= a_fwd;
    end
  end

`ifndef SYNTHESIS
  a_dead_zero: assert property (@(posedge clk) disable iff (rst)
    (a_adv && a_dead) |=> (out_pwm == '0))
    else $error("dead zone transaction gave nonzero drive");
  a_min_drive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_pwm != '0)) |-> (out_pwm >= cfg.min_drive))
    else $error("drive below minimum not forced to zero");
`endif

endmodule

// ===== sv/motor_ramp_incremental_pid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_ramp_incremental_pid
// Multi-channel motor speed controller: target ramp plus incremental pid.
// ----------------------------------------------------------------------------
// a target transaction passes the f1, f2, queue, a and output registers in order
// throughput: one transaction per cycle unless the output stalls, set by the per-channel
//   state being read and written in the same stage (errors at issue, accumulator at output)
// measurement transactions update state and give no result
// reset: registers to defaults, channel state cleared, pipeline emptied
module motor_ramp_incremental_pid #(
  parameter int CHANNELS       = mrip_pkg::DEF_CHANNELS,
  parameter int GAIN_FRAC_BITS = mrip_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [mrip_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // channel, speed_value
  input  logic                              s_axis_tuser,  // op
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [mrip_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // out_channel, pwm_compare, forward
  input  logic                              cfg_we,
  input  logic [mrip_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [mrip_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mrip_pkg::*;

  cfg_t             cfg;
  logic             push;
  cmd_t             push_cmd;
  logic             q_full;
  logic             pop;
  cmd_t             head;
  logic             q_empty;
  logic [CH_W-1:0]    out_ch;
  logic [DRIVE_W-1:0] out_pwm;
  logic               out_fwd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p          <= RST_GAIN_P;
      cfg.gain_i          <= RST_GAIN_I;
      cfg.gain_d          <= RST_GAIN_D;
      cfg.drive_limit     <= RST_DRIVE_LIMIT;
      cfg.error_dead_zone <= RST_DEAD_ZONE;
      cfg.speed_ceiling   <= RST_SPEED_CEIL;
      cfg.ramp_step       <= RST_RAMP_STEP;
      cfg.min_drive       <= RST_MIN_DRIVE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_P:      cfg.gain_p          <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:      cfg.gain_i          <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:      cfg.gain_d          <= cfg_data[GAIN_W-1:0];
        REG_DRIVE_LIMIT: cfg.drive_limit     <= cfg_data;
        REG_DEAD_ZONE:   cfg.error_dead_zone <= cfg_data;
        REG_SPEED_CEIL:  cfg.speed_ceiling   <= cfg_data;
        REG_RAMP_STEP:   cfg.ramp_step       <= cfg_data;
        REG_MIN_DRIVE:   cfg.min_drive       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mrip_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_op    (s_axis_tuser),
    .in_ch    (s_axis_tdata[CH_W-1:0]),
    .in_speed (s_axis_tdata[CH_W +: SPEED_W]),
    .cfg      (cfg),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  mrip_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  mrip_back #(
    .CHANNELS       (CHANNELS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_ch    (out_ch),
    .out_pwm   (out_pwm),
    .out_fwd   (out_fwd)
  );

  assign m_axis_tdata = OUT_TDATA_W'({out_fwd, out_pwm, out_ch});

endmodule

// ===== bench/motor_ramp_incremental_pid_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_ramp_incremental_pid_checker
// Watches the input, output and register ports of the speed controller. Each
// accepted target transaction is run through a local ramp and incremental pid
// model that keeps its own channel state and register copy, and the expected
// drive is queued. Each accepted output transaction is compared field by
// field with the oldest queued drive.
// ----------------------------------------------------------------------------
module motor_ramp_incremental_pid_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [mrip_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // channel, speed_value
  input  logic                             s_axis_tuser,  // op
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [mrip_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // out_channel, pwm_compare, forward
  input  logic                             cfg_we,
  input  logic [mrip_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [mrip_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               mismatches,
  output int                               pending
);
  import mrip_pkg::*;

  localparam int ACC_W = 24;
  localparam int FRAC  = DEF_GAIN_FRAC_BITS;

  typedef struct packed {
    logic [CH_W-1:0]    ch;
    logic [DRIVE_W-1:0] pwm;
    logic               fwd;
  } drive_t;

  cfg_t                      regs_q;
  logic signed [SPEED_W-1:0] meas_rpm  [DEF_CHANNELS];
  logic signed [ERR_W-1:0]   err_last  [DEF_CHANNELS];
  logic signed [ERR_W-1:0]   err_prior [DEF_CHANNELS];
  logic signed [ACC_W-1:0]   accum     [DEF_CHANNELS];
  drive_t                    drive_queue [$];

  int fails   = 0;
  int waiting = 0;
  assign mismatches = fails;
  assign pending    = waiting;

  drive_t                    got;
  drive_t                    want;
  logic [CH_W-1:0]           in_ch;
  logic signed [SPEED_W-1:0] in_speed;

  task automatic report(input string what);
    $display("%0t mismatch: %s", $time, what);
    fails++;
  endtask

  function automatic longint mag(input longint v);
    return v < 0 ? -v : v;
  endfunction

  // ramp the target from the measurement, then one incremental pid update outside the dead zone
  function automatic drive_t command_drive(input logic [CH_W-1:0] ch,
                                           input logic signed [SPEED_W-1:0] speed);
    longint ceil_v, ramp_v, dead_v, gp, gi, gd, lim, min_v;
    longint tgt, cur, diff, step, ramped, err, le, pe, acc, pwm;
    drive_t d;
    ceil_v = longint'(regs_q.speed_ceiling);
    ramp_v = longint'(regs_q.ramp_step);
    dead_v = longint'(regs_q.error_dead_zone);
    gp     = longint'(regs_q.gain_p);
    gi     = longint'(regs_q.gain_i);
    gd     = longint'(regs_q.gain_d);
    lim    = longint'(regs_q.drive_limit) << FRAC;
    min_v  = longint'(regs_q.min_drive);

    tgt = longint'(speed);
    if (tgt > ceil_v) tgt = ceil_v;
    if (tgt < -ceil_v) tgt = -ceil_v;

    cur  = longint'(meas_rpm[ch]);
    diff = tgt - cur;
    step = ramp_v;
    if (mag(diff) < 2 * step) step = ramp_v >> 1;
    if (mag(diff) < step) ramped = tgt;
    else ramped = diff > 0 ? cur + step : cur - step;

    d.ch  = ch;
    d.fwd = ramped >= 0;
    err   = mag(ramped) - mag(cur);
    if (mag(err) < dead_v) begin
      d.pwm = '0;
    end else begin
      le  = longint'(err_last[ch]);
      pe  = longint'(err_prior[ch]);
      acc = longint'(accum[ch]) + gp * (err - le) + gi * err + gd * (err - 2 * le + pe);
      if (acc > lim) acc = lim;
      if (acc < -lim) acc = -lim;
      accum[ch]     = acc[ACC_W-1:0];
      err_prior[ch] = le[ERR_W-1:0];
      err_last[ch]  = err[ERR_W-1:0];
      pwm = acc < 0 ? 0 : acc >>> FRAC;
      if (pwm < min_v) pwm = 0;
      d.pwm = pwm[DRIVE_W-1:0];
    end
    return d;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      regs_q = '{gain_p: RST_GAIN_P, gain_i: RST_GAIN_I, gain_d: RST_GAIN_D,
                 drive_limit: RST_DRIVE_LIMIT, error_dead_zone: RST_DEAD_ZONE,
                 speed_ceiling: RST_SPEED_CEIL, ramp_step: RST_RAMP_STEP,
                 min_drive: RST_MIN_DRIVE};
      for (int i = 0; i < DEF_CHANNELS; i++) begin
        meas_rpm[i]  = '0;
        err_last[i]  = '0;
        err_prior[i] = '0;
        accum[i]     = '0;
      end
      drive_queue.delete();
      waiting <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN_P:      regs_q.gain_p          = cfg_data[GAIN_W-1:0];
          REG_GAIN_I:      regs_q.gain_i          = cfg_data[GAIN_W-1:0];
          REG_GAIN_D:      regs_q.gain_d          = cfg_data[GAIN_W-1:0];
          REG_DRIVE_LIMIT: regs_q.drive_limit     = cfg_data;
          REG_DEAD_ZONE:   regs_q.error_dead_zone = cfg_data;
          REG_SPEED_CEIL:  regs_q.speed_ceiling   = cfg_data;
          REG_RAMP_STEP:   regs_q.ramp_step       = cfg_data;
          REG_MIN_DRIVE:   regs_q.min_drive       = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_ch    = s_axis_tdata[CH_W-1:0];
        in_speed = s_axis_tdata[CH_W +: SPEED_W];
        if (s_axis_tuser == OP_MEASURE) meas_rpm[in_ch] = in_speed;
        else drive_queue.push_back(command_drive(in_ch, in_speed));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.ch  = m_axis_tdata[CH_W-1:0];
        got.pwm = m_axis_tdata[CH_W +: DRIVE_W];
        got.fwd = m_axis_tdata[CH_W + DRIVE_W];
        if (drive_queue.size() == 0) begin
          report($sformatf("unexpected drive ch%0d pwm %0d fwd %0d",
                           got.ch, got.pwm, got.fwd));
        end else begin
          want = drive_queue.pop_front();
          if (got.ch != want.ch)
            report($sformatf("channel %0d, want %0d", got.ch, want.ch));
          if (got.pwm != want.pwm)
            report($sformatf("ch%0d pwm %0d, want %0d", want.ch, got.pwm, want.pwm));
          if (got.fwd != want.fwd)
            report($sformatf("ch%0d forward %0d, want %0d", want.ch, got.fwd, want.fwd));
        end
      end
      waiting <= drive_queue.size();
    end
  end

endmodule

// ===== bench/motor_ramp_incremental_pid_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_ramp_incremental_pid_tb
// Drives the speed controller with a short directed sequence (field extremes,
// ceiling clamp, each ramp step case, dead zone, accumulator growth in both
// ways) and then with mostly measure-then-command pairs that follow a simple
// per-channel plant, mixed with lone commands and full-range noise. Several
// register settings are visited, the extremes among them, each written while
// the block is idle. Both sides idle at random; the checker does the scoring.
// ----------------------------------------------------------------------------
module motor_ramp_incremental_pid_tb;
  import mrip_pkg::*;

  localparam int PHASE_ITEMS = 200;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;  // channel, speed_value
  logic                   s_axis_tuser = 1'b0;  // op
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;  // out_channel, pwm_compare, forward
  logic                   cfg_we = 1'b0;
  logic [REG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int mismatches;
  int pending;
  bit calm = 1'b0;
  int plant [DEF_CHANNELS] = '{default: 0};

  motor_ramp_incremental_pid i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  motor_ramp_incremental_pid_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  always #5 clk = ~clk;

  function automatic int idle_cycles();
    if (calm) return 0;
    return $urandom_range(0, 7);
  endfunction

  task automatic send(input logic op, input logic [CH_W-1:0] ch, input int val);
    int n;
    n = idle_cycles();
    if ($urandom_range(0, 39) == 0) calm = !calm;
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, val[SPEED_W-1:0], ch};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // let every queued drive come out and the pipeline drain
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  task automatic configure(input int gp, input int gi, input int gd, input int lim,
                           input int dead, input int ceil_v, input int ramp,
                           input int min_v);
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_DRIVE_LIMIT, lim);
    write_reg(REG_DEAD_ZONE, dead);
    write_reg(REG_SPEED_CEIL, ceil_v);
    write_reg(REG_RAMP_STEP, ramp);
    write_reg(REG_MIN_DRIVE, min_v);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int items);
    int count;
    int r;
    int ch;
    int meas;
    int tgt;
    count = 0;
    while (count < items) begin
      r   = $urandom_range(0, 99);
      ch  = $urandom_range(0, DEF_CHANNELS - 1);
      tgt = int'($urandom_range(0, 40000)) - 20000;
      if (r < 70) begin
        // measurement near the last command, then a new command
        meas = plant[ch] + int'($urandom_range(0, 3000)) - 1500;
        if (meas > 32767) meas = 32767;
        if (meas < -32768) meas = -32768;
        send(OP_MEASURE, CH_W'(ch), meas);
        send(OP_TARGET, CH_W'(ch), tgt);
        plant[ch] = tgt;
        count += 2;
      end else if (r < 85) begin
        send(OP_TARGET, CH_W'(ch), tgt);
        plant[ch] = tgt;
        count++;
      end else begin
        send(1'($urandom_range(0, 1)), CH_W'(ch), int'($urandom_range(0, 65535)));
        count++;
      end
    end
  endtask

  initial begin
    m_axis_tready <= 1'b0;
    wait (!rst);
    forever begin
      int n;
      n = idle_cycles();
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset register values
    send(OP_TARGET, 0, 0);            // no difference, dead zone
    send(OP_TARGET, 0, 32767);        // ceiling clamp, full step
    send(OP_TARGET, 1, -32768);       // negative clamp, reverse
    send(OP_MEASURE, 2, 32767);
    send(OP_TARGET, 2, -32768);
    send(OP_MEASURE, 3, -32768);
    send(OP_TARGET, 3, -32768);
    send(OP_MEASURE, 0, 500);
    send(OP_TARGET, 0, 1800);         // half step
    send(OP_MEASURE, 0, 1000);
    send(OP_TARGET, 0, 1300);         // target within the step
    send(OP_MEASURE, 1, 2000);
    send(OP_TARGET, 1, 2020);         // inside the dead zone
    send(OP_MEASURE, 3, 0);
    send(OP_TARGET, 3, 9500);         // accumulator grows toward the limit
    send(OP_TARGET, 3, 9500);
    send(OP_TARGET, 3, 9500);
    send(OP_TARGET, 3, 9500);
    send(OP_MEASURE, 2, 5000);
    send(OP_TARGET, 2, 0);            // accumulator negative
    send(OP_TARGET, 2, 0);
    send(OP_MEASURE, 1, -1);
    send(OP_TARGET, 1, 1);            // sign crossing
    run_random(PHASE_ITEMS);
    settle();

    configure(4095, 4095, 4095, 16383, 16383, 16383, 16383, 16383);
    run_random(PHASE_ITEMS);
    settle();
    configure(0, 0, 0, 0, 0, 0, 0, 0);
    run_random(PHASE_ITEMS);
    settle();
    configure(4095, 4095, 4095, 16383, 0, 16383, 16383, 0);
    run_random(PHASE_ITEMS);
    settle();
    repeat (2) begin
      configure($urandom_range(0, 1023), $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 16383), $urandom_range(0, 200),
                $urandom_range(0, 16383), $urandom_range(0, 4000),
                $urandom_range(0, 500));
      run_random(PHASE_ITEMS);
      settle();
    end
    configure(int'(RST_GAIN_P), int'(RST_GAIN_I), int'(RST_GAIN_D),
              int'(RST_DRIVE_LIMIT), int'(RST_DEAD_ZONE), int'(RST_SPEED_CEIL),
              int'(RST_RAMP_STEP), int'(RST_MIN_DRIVE));
    run_random(PHASE_ITEMS);
    settle();
    repeat (10) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("motor_ramp_incremental_pid_tb: clean");
    end else begin
      $display("motor_ramp_incremental_pid_tb: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("motor_ramp_incremental_pid_tb: errors");
    $finish;
  end

endmodule
